@@ design/bezier_de_casteljau_eval_top_defines.svh @@
// Assertion macros for the curve evaluator datapath.
// Depends on nothing; included by the files that carry checks.
`ifndef BEZIER_DE_CASTELJAU_EVAL_TOP_DEFINES_SVH
`define BEZIER_DE_CASTELJAU_EVAL_TOP_DEFINES_SVH
`ifndef SYNTH
`define BDC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication check failed");
`define BDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");
`else
`define BDC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define BDC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ design/bdc_pkg.sv @@
// Types, constants and the microcode program of the curve evaluator.
// Used by the sequencer, the datapath and the top level.
package bdc_pkg;

  localparam int unsigned T_W         = 17;
  localparam int unsigned T_FRAC_BITS = 16;
  localparam logic [T_W-1:0] T_ONE    = 17'h10000;
  localparam int unsigned INDEX_W     = 3;
  localparam int unsigned PCOUNT_W    = 4;
  localparam logic [PCOUNT_W-1:0] PCOUNT_RESET = 4'd4;

  typedef logic [2:0] step_t;

  typedef enum logic [2:0] {
    UOP_WAIT,
    UOP_FETCH,
    UOP_SETTLE,
    UOP_MUL,
    UOP_ADD,
    UOP_DROP,
    UOP_EMIT,
    UOP_NOP
  } uop_t;

  typedef enum logic [2:0] {
    COND_NONE,
    COND_ALWAYS,
    COND_NO_EVAL,
    COND_FETCH_MORE,
    COND_LEVEL_MORE,
    COND_LEVELS_MORE,
    COND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    uop_t  uop;
    cond_t cond;
    step_t target;
  } ucode_t;

  typedef struct packed {
    uop_t uop;
  } bdc_ctrl_t;

  typedef struct packed {
    logic eval_go;
    logic fetch_more;
    logic level_more;
    logic levels_more;
    logic out_busy;
  } bdc_status_t;

  localparam step_t STEP_WAIT   = 3'd0;
  localparam step_t STEP_FETCH  = 3'd1;
  localparam step_t STEP_SETTLE = 3'd2;
  localparam step_t STEP_MUL    = 3'd3;
  localparam step_t STEP_ADD    = 3'd4;
  localparam step_t STEP_DROP   = 3'd5;
  localparam step_t STEP_EMIT   = 3'd6;
  localparam step_t STEP_RETURN = 3'd7;

  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t word;
    unique case (step)
      STEP_WAIT:   word = '{uop: UOP_WAIT,   cond: COND_NO_EVAL,     target: STEP_WAIT};
      STEP_FETCH:  word = '{uop: UOP_FETCH,  cond: COND_FETCH_MORE,  target: STEP_FETCH};
      STEP_SETTLE: word = '{uop: UOP_SETTLE, cond: COND_NONE,        target: STEP_WAIT};
      STEP_MUL:    word = '{uop: UOP_MUL,    cond: COND_NONE,        target: STEP_WAIT};
      STEP_ADD:    word = '{uop: UOP_ADD,    cond: COND_LEVEL_MORE,  target: STEP_MUL};
      STEP_DROP:   word = '{uop: UOP_DROP,   cond: COND_LEVELS_MORE, target: STEP_MUL};
      STEP_EMIT:   word = '{uop: UOP_EMIT,   cond: COND_OUT_BUSY,    target: STEP_EMIT};
      STEP_RETURN: word = '{uop: UOP_NOP,    cond: COND_ALWAYS,      target: STEP_WAIT};
      default:     word = '{uop: UOP_NOP,    cond: COND_ALWAYS,      target: STEP_WAIT};
    endcase
    return word;
  endfunction

endpackage

@@ design/bdc_sequencer.sv @@
// Microcode sequencer: step counter, program table and jump conditions.
// Depends on bdc_pkg for the control word and status types.
module bdc_sequencer
  import bdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  bdc_status_t status,
  output bdc_ctrl_t   ctrl
);

  step_t  step_r;
  step_t  step_nxt;
  ucode_t word;
  logic   take_jump;

  assign word = ucode_rom(step_r);

  always_comb begin
    unique case (word.cond)
      COND_NONE:        take_jump = 1'b0;
      COND_ALWAYS:      take_jump = 1'b1;
      COND_NO_EVAL:     take_jump = !status.eval_go;
      COND_FETCH_MORE:  take_jump = status.fetch_more;
      COND_LEVEL_MORE:  take_jump = status.level_more;
      COND_LEVELS_MORE: take_jump = status.levels_more;
      COND_OUT_BUSY:    take_jump = status.out_busy;
      default:          take_jump = 1'b1;
    endcase
    step_nxt = take_jump ? word.target : step_r + step_t'(1);
  end

  always_comb begin
    ctrl.uop = word.uop;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_WAIT;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

@@ design/bdc_datapath.sv @@
// Point store, work queue, interpolation unit and output register.
// Depends on bdc_pkg and on the assertion macro header.
`include "bezier_de_casteljau_eval_top_defines.svh"
module bdc_datapath
  import bdc_pkg::*;
#(
  parameter int unsigned MAX_POINTS  = 8,
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bdc_ctrl_t                  ctrl,
  output bdc_status_t                status,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_operation,
  input  logic [INDEX_W-1:0]         in_index,
  input  logic [3*COORD_WIDTH-1:0]   in_point,
  input  logic [T_W-1:0]             in_t,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [3*COORD_WIDTH-1:0]   out_point,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [PCOUNT_W-1:0]        cfg_data
);

  localparam int unsigned CW    = COORD_WIDTH;
  localparam int unsigned IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned NW    = $clog2(MAX_POINTS + 1);
  localparam int unsigned PW    = CW + T_FRAC_BITS + 3;

  logic [PCOUNT_W-1:0]       pc_r;
  logic [NW-1:0]             n_r;
  logic [NW-1:0]             n_clamp;
  logic [T_W-1:0]            t_r;
  logic [IDX_W-1:0]          cnt_r;
  logic                      rd_vld_r;
  logic [IDX_W-1:0]          rd_idx_r;
  logic [3*CW-1:0]           rd_data_r;
  logic [3*CW-1:0]           store_mem [MAX_POINTS];
  logic signed [CW-1:0]      w_r [MAX_POINTS][3];
  logic signed [CW-1:0]      p_r [3];
  logic signed [PW-1:0]      prod_r [3];
  logic signed [CW:0]        diff [3];
  logic signed [CW-1:0]      lerp [3];
  logic signed [T_W:0]       t_s;
  logic [NW-1:0]             m_r;
  logic [IDX_W-1:0]          j_r;
  logic                      out_valid_r;
  logic [3*CW-1:0]           out_data_r;
  logic                      accept;
  logic                      store_we;
  logic                      emit_load;

  assign in_ready  = (ctrl.uop == UOP_WAIT);
  assign accept    = in_valid && in_ready;
  assign store_we  = accept && !in_operation && (32'(in_index) < MAX_POINTS);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_point = out_data_r;

  always_comb begin
    if (32'(pc_r) > MAX_POINTS) begin
      n_clamp = NW'(MAX_POINTS);
    end else if (pc_r < PCOUNT_W'(2)) begin
      n_clamp = NW'(2);
    end else begin
      n_clamp = NW'(pc_r);
    end
  end

  assign status.eval_go     = accept && in_operation;
  assign status.fetch_more  = (NW'(cnt_r) != n_r - NW'(1));
  assign status.level_more  = (NW'(j_r) != m_r - NW'(2));
  assign status.levels_more = (m_r != NW'(2));
  assign status.out_busy    = out_valid_r && !out_ready;
  assign emit_load          = (ctrl.uop == UOP_EMIT) && !status.out_busy;

  assign t_s = $signed({1'b0, t_r});

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      diff[c] = (CW+1)'(w_r[1][c]) - (CW+1)'(w_r[0][c]);
      lerp[c] = p_r[c] + $signed(prod_r[c][CW+T_FRAC_BITS-1:T_FRAC_BITS]);
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem[IDX_W'(in_index)] <= in_point;
    end
    rd_data_r <= store_mem[cnt_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= PCOUNT_RESET;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
      cnt_r       <= '0;
      m_r         <= NW'(2);
      j_r         <= '0;
      n_r         <= NW'(2);
    end else begin
      if (cfg_valid && cfg_ready) begin
        pc_r <= cfg_data;
      end
      rd_vld_r <= (ctrl.uop == UOP_FETCH);
      if (emit_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (ctrl.uop)
        UOP_WAIT: begin
          if (status.eval_go) begin
            n_r   <= n_clamp;
            cnt_r <= '0;
          end
        end
        UOP_FETCH: cnt_r <= cnt_r + IDX_W'(1);
        UOP_SETTLE: begin
          m_r <= n_r;
          j_r <= '0;
        end
        UOP_ADD: j_r <= j_r + IDX_W'(1);
        UOP_DROP: begin
          m_r <= m_r - NW'(1);
          j_r <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= cnt_r;
    if (status.eval_go) begin
      t_r <= (in_t > T_ONE) ? T_ONE : in_t;
    end
    if (emit_load) begin
      out_data_r <= {w_r[0][2], w_r[0][1], w_r[0][0]};
    end
    if (ctrl.uop == UOP_MUL) begin
      for (int c = 0; c < 3; c++) begin
        prod_r[c] <= PW'(diff[c]) * PW'(t_s);
        p_r[c]    <= w_r[0][c];
      end
    end
    if (rd_vld_r) begin
      for (int c = 0; c < 3; c++) begin
        w_r[rd_idx_r][c] <= $signed(rd_data_r[c*CW +: CW]);
      end
    end else if (ctrl.uop == UOP_ADD || ctrl.uop == UOP_DROP) begin
      for (int k = 0; k < MAX_POINTS - 1; k++) begin
        for (int c = 0; c < 3; c++) begin
          w_r[k][c] <= w_r[k+1][c];
        end
      end
      if (ctrl.uop == UOP_ADD) begin
        for (int c = 0; c < 3; c++) begin
          w_r[IDX_W'(m_r - NW'(1))][c] <= lerp[c];
        end
      end
    end
  end

  `BDC_ASSERT_IMPL(a_fetch_in_range, clk, rst_n, rd_vld_r, (NW'(rd_idx_r) < n_r))
  `BDC_ASSERT_IMPL(a_mul_level_ok, clk, rst_n, (ctrl.uop == UOP_MUL),
                   ((NW'(j_r) + NW'(2) <= m_r) && (m_r <= n_r) && (m_r >= NW'(2))))
  `BDC_ASSERT_IMPL(a_out_from_emit, clk, rst_n, $rose(out_valid_r), $past(ctrl.uop == UOP_EMIT))

endmodule

@@ design/bezier_de_casteljau_eval_top.sv @@
// Bezier curve evaluator top level: stream channels and configuration port.
// Depends on bdc_pkg, bdc_sequencer and bdc_datapath.
//
// The in_ channel carries one beat per item. in_tuser holds the operation:
// zero loads a control point into slot point_index, one evaluates the curve
// at param_t. A load produces no output beat and keeps the block idle, so
// loads can stream at one beat per cycle while no evaluate is running. An
// evaluate copies the first n stored points into a work queue (n is
// point_count clamped to 2..MAX_POINTS), then runs de Casteljau levels
// through one multiplier per coordinate. Each interpolation is a multiply
// step followed by an add step, and each level ends with a drop step.
// The next item is taken only after the evaluate has passed its emit
// step and the block is back in its wait step.
// The result sits in an output register; a stalled receiver does not block
// the next item, only the emit step of the following evaluate waits.
// cfg_ writes point_count and are always ready; write only while idle.
// Reset sets point_count to four and empties the output register; store
// contents are undefined until loaded.
module bezier_de_casteljau_eval_top
  import bdc_pkg::*;
#(
  parameter int unsigned MAX_POINTS  = 8,
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // point_index, coord_x, coord_y, coord_z, param_t, zero pad
  input  logic [((INDEX_W + 3*COORD_WIDTH + T_W + 7) / 8) * 8 - 1:0] in_tdata,
  // operation
  input  logic [0:0] in_tuser,
  output logic out_tvalid,
  input  logic out_tready,
  // curve_x, curve_y, curve_z, zero pad
  output logic [((3*COORD_WIDTH + 7) / 8) * 8 - 1:0] out_tdata,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [PCOUNT_W-1:0] cfg_data
);

  localparam int unsigned CW      = COORD_WIDTH;
  localparam int unsigned OUT_W   = ((3*CW + 7) / 8) * 8;

  bdc_ctrl_t          ctrl;
  bdc_status_t        status;
  logic [3*CW-1:0]    out_point;

  bdc_sequencer u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl)
  );

  bdc_datapath #(
    .MAX_POINTS  (MAX_POINTS),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctrl         (ctrl),
    .status       (status),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_operation (in_tuser[0]),
    .in_index     (in_tdata[INDEX_W-1:0]),
    .in_point     (in_tdata[INDEX_W +: 3*CW]),
    .in_t         (in_tdata[INDEX_W + 3*CW +: T_W]),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_point    (out_point),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  assign out_tdata = OUT_W'(out_point);

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for bezier_de_casteljau_eval_top: loads control points,
// evaluates curves under random stalls, and checks every output beat against a
// local de Casteljau predictor. Depends on bdc_pkg and the design top level.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import bdc_pkg::*;

  localparam int unsigned COORD_W = 16;
  localparam int unsigned NUM_SLOTS = 8;
  localparam int unsigned IN_W = ((INDEX_W + 3*COORD_W + T_W + 7) / 8) * 8;
  localparam int unsigned OUT_W = ((3*COORD_W + 7) / 8) * 8;
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned PHASES = 8;
  localparam int unsigned PHASE_ITEMS = 150;

  typedef struct packed {
    logic signed [COORD_W-1:0] z;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } point_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_W-1:0] in_tdata;
  logic [0:0] in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_W-1:0] out_tdata;
  logic cfg_valid;
  logic cfg_ready;
  logic [PCOUNT_W-1:0] cfg_data;

  point_t ctrl_pts [NUM_SLOTS];
  logic [PCOUNT_W-1:0] point_count;
  point_t expected_points[$];
  int unsigned errors;
  int unsigned cycles;
  bit burst_mode;

  bezier_de_casteljau_eval_top uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** bezier_de_casteljau_eval_top: FAILED **");
      $finish;
    end
  end

  function automatic longint lerp_coord(longint p, longint q, longint t);
    longint prod;
    prod = (q - p) * t;
    return p + (prod >>> 16);
  endfunction

  function automatic point_t eval_curve(logic [T_W-1:0] t_in);
    longint work [NUM_SLOTS][3];
    longint t;
    int n;
    point_t res;
    t = (t_in > T_ONE) ? longint'(T_ONE) : longint'(t_in);
    n = point_count;
    if (n < 2) n = 2;
    if (n > NUM_SLOTS) n = NUM_SLOTS;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      work[i][0] = ctrl_pts[i].x;
      work[i][1] = ctrl_pts[i].y;
      work[i][2] = ctrl_pts[i].z;
    end
    for (int k = 1; k < n; k++)
      for (int i = 0; i + k < n; i++)
        for (int c = 0; c < 3; c++)
          work[i][c] = lerp_coord(work[i][c], work[i+1][c], t);
    res.x = 16'(work[0][0]);
    res.y = 16'(work[0][1]);
    res.z = 16'(work[0][2]);
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'h8000;
    if (r < 20) return 16'h7fff;
    if (r < 25) return '0;
    return COORD_W'($urandom());
  endfunction

  function automatic logic [T_W-1:0] rand_param();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return T_ONE;
    if (r < 30) return T_W'($urandom_range(65537, 131071));
    return T_W'($urandom_range(0, 65535));
  endfunction

  // Called at a falling edge; returns at a falling edge after the optional gap.
  task automatic send_beat(input logic op, input logic [INDEX_W-1:0] idx, input point_t pt,
                           input logic [T_W-1:0] t);
    int unsigned gap;
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= IN_W'({t, pt.z, pt.y, pt.x, idx});
    do @(posedge clk); while (!in_tready);
    if (op == OP_LOAD) begin
      ctrl_pts[idx] = pt;
    end else begin
      expected_points = {expected_points, eval_curve(t)};
    end
    @(negedge clk);
    gap = pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic load_point(input logic [INDEX_W-1:0] idx, input point_t pt);
    send_beat(OP_LOAD, idx, pt, rand_param());
  endtask

  task automatic eval_at(input logic [T_W-1:0] t);
    point_t junk;
    junk = {rand_coord(), rand_coord(), rand_coord()};
    send_beat(OP_EVAL, INDEX_W'($urandom_range(0, NUM_SLOTS-1)), junk, t);
  endtask

  // The block returns to idle once it has loaded its last result into the output register.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_point_count(input logic [PCOUNT_W-1:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    point_count = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_count();
    load_point(3'd0, '{x: 16'sh8000, y: 16'sh7fff, z: 16'sh0000});
    load_point(3'd1, '{x: 16'sh7fff, y: 16'sh8000, z: 16'sh0100});
    load_point(3'd2, '{x: 16'sh8000, y: 16'sh8000, z: 16'sh7fff});
    load_point(3'd3, '{x: 16'sh7fff, y: 16'sh7fff, z: 16'sh8000});
    for (int i = 4; i < NUM_SLOTS; i++)
      load_point(INDEX_W'(i), {rand_coord(), rand_coord(), rand_coord()});
    eval_at('0);
    eval_at(T_ONE);
    eval_at(17'd32768);
  endtask

  task automatic test_param_edges();
    eval_at(17'h1ffff);
    eval_at(17'd65537);
    eval_at(17'd1);
    eval_at(17'd65535);
  endtask

  task automatic test_point_counts();
    logic [PCOUNT_W-1:0] counts[6] = '{4'd0, 4'd1, 4'd2, 4'd8, 4'd15, 4'd9};
    foreach (counts[i]) begin
      set_point_count(counts[i]);
      eval_at(rand_param());
    end
  endtask

  task automatic test_random_items();
    logic [PCOUNT_W-1:0] value;
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) value = 4'd8;
      else if (ph == 1) value = 4'd2;
      else value = PCOUNT_W'($urandom_range(0, 15));
      set_point_count(value);
      burst_mode = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 99) < 40)
          load_point(INDEX_W'($urandom_range(0, NUM_SLOTS-1)),
                     {rand_coord(), rand_coord(), rand_coord()});
        else
          eval_at(rand_param());
      end
      burst_mode = 1'b0;
    end
  endtask

  initial begin
    int unsigned hold;
    logic level;
    out_tready = 1'b0;
    forever begin
      level = ($urandom_range(0, 99) < 70);
      if (level)
        hold = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 5);
      else
        hold = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
      @(negedge clk);
      out_tready <= level;
      repeat (hold - 1) @(negedge clk);
    end
  end

  always @(posedge clk) begin : check_results
    point_t want;
    point_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[3*COORD_W-1:0];
      if (expected_points.size() == 0) begin
        $error("result beat with no evaluate pending: %h", out_tdata);
        errors++;
      end else begin
        want = expected_points.pop_front();
        if (got.x !== want.x) begin
          $error("curve_x mismatch: expected %0d, actual %0d", want.x, got.x);
          errors++;
        end
        if (got.y !== want.y) begin
          $error("curve_y mismatch: expected %0d, actual %0d", want.y, got.y);
          errors++;
        end
        if (got.z !== want.z) begin
          $error("curve_z mismatch: expected %0d, actual %0d", want.z, got.z);
          errors++;
        end
      end
    end
  end

  initial begin
    errors = 0;
    cycles = 0;
    burst_mode = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    point_count = PCOUNT_RESET;
    foreach (ctrl_pts[i]) ctrl_pts[i] = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_count();
    test_param_edges();
    test_point_counts();
    test_random_items();
    wait_idle();
    if (errors == 0) begin
      $display("** bezier_de_casteljau_eval_top: PASSED **");
    end else begin
      $display("** bezier_de_casteljau_eval_top: FAILED **");
    end
    $finish;
  end

endmodule
